>>> rtl/core/fbi_pkg.sv
// Package: shared constants and types for the filleted box indicator.
package fbi_pkg;

  localparam int unsigned RegBits = 23;
  localparam int unsigned CfgIdxBits = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    RegHalfX  = 3'd0,
    RegHalfY  = 3'd1,
    RegHalfZ  = 3'd2,
    RegFillet = 3'd3,
    RegFuzz   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    RegionFace  = 2'd0,
    RegionNorm  = 2'd1,
    RegionOut   = 2'd2,
    RegionBad   = 2'd3
  } region_e;

endpackage

>>> rtl/core/fbi_root.sv
// Pipelined integer square root, one result bit per stage.
module fbi_root #(
  parameter int unsigned InBits  = 52,
  parameter int unsigned OutBits = 26,
  parameter int unsigned TagBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [InBits-1:0]  rad_i,
  input  logic [TagBits-1:0] tag_i,
  output logic               valid_o,
  output logic [OutBits-1:0] root_o,
  output logic [TagBits-1:0] tag_o
);

  localparam int unsigned RemBits = OutBits + 2;
  localparam int unsigned PadBits = 2 * OutBits;

  logic [OutBits:0]     vld_q;
  logic [PadBits-1:0]   rad_q  [OutBits+1];
  logic [RemBits-1:0]   rem_q  [OutBits+1];
  logic [OutBits-1:0]   root_q [OutBits+1];
  logic [TagBits-1:0]   tag_q  [OutBits+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rad_q[0]  = PadBits'(rad_i);
    rem_q[0]  = '0;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  for (genvar s = 0; s < OutBits; s++) begin : g_stage
    logic [RemBits-1:0] trial_d;
    logic [RemBits-1:0] rem_d;
    logic [RemBits-1:0] sub_d;
    logic [OutBits-1:0] root_d;
    logic               vld_r;
    logic [PadBits-1:0] rad_r;
    logic [RemBits-1:0] rem_r;
    logic [OutBits-1:0] root_r;
    logic [TagBits-1:0] tag_r;

    always_comb begin
      trial_d = {rem_q[s][RemBits-3:0], rad_q[s][PadBits-1 -: 2]};
      sub_d   = {root_q[s], 2'b01};
      if (trial_d >= sub_d) begin
        rem_d  = trial_d - sub_d;
        root_d = {root_q[s][OutBits-2:0], 1'b1};
      end else begin
        rem_d  = trial_d;
        root_d = {root_q[s][OutBits-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rad_r  <= {rad_q[s][PadBits-3:0], 2'b00};
      rem_r  <= rem_d;
      root_r <= root_d;
      tag_r  <= tag_q[s];
    end

    always_comb begin
      vld_q[s+1]  = vld_r;
      rad_q[s+1]  = rad_r;
      rem_q[s+1]  = rem_r;
      root_q[s+1] = root_r;
      tag_q[s+1]  = tag_r;
    end
  end

  assign valid_o = vld_q[OutBits];
  assign root_o  = root_q[OutBits];
  assign tag_o   = tag_q[OutBits];

endmodule

>>> rtl/core/filleted_box_indicator.sv
// Top level: fuzzy occupancy of a box with filleted edges, fully pipelined.
//
//  port group      dir  meaning
//  start_i/busy_o  in/out request of one point (point_x/y/z_i)
//  cfg_*_i         in   register write, index selects the register
//  done_o          out  strobe, one cycle, with occupancy_o/config_invalid_o
//
// One request per cycle; busy_o is always low. The pipeline runs through
// 4 front stages, the bit-per-stage root, a limits stage, the bit-per-stage
// divider and the output register. Reset clears the configuration
// registers and the valid chain; results in flight are dropped.
// The receiver cannot hold results off, so the pipeline never stalls.
module filleted_box_indicator #(
  parameter int unsigned COORD_BITS    = 24,
  parameter int unsigned OCC_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [COORD_BITS-1:0]  point_x_i,
  input  logic signed [COORD_BITS-1:0]  point_y_i,
  input  logic signed [COORD_BITS-1:0]  point_z_i,
  input  logic                          cfg_we_i,
  input  logic [fbi_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [fbi_pkg::RegBits-1:0]   cfg_data_i,
  output logic                          done_o,
  output logic [OCC_FRAC_BITS:0]        occupancy_o,
  output logic                          config_invalid_o
);

  localparam int unsigned RB = fbi_pkg::RegBits;
  // widths wide enough for both coordinates and registers
  localparam int unsigned AB = ((COORD_BITS > RB) ? COORD_BITS : RB) + 1;
  localparam int unsigned SqB = 2 * AB + 2;
  localparam int unsigned RtB = AB + 1;
  localparam int unsigned DB  = RtB + 2;         // signed distance
  localparam int unsigned NB  = RB + 2;           // numerator / denominator
  localparam int unsigned QB  = OCC_FRAC_BITS;
  localparam int unsigned TagB = 2 + DB;

  logic [RB-1:0] hx_q, hy_q, hz_q, fr_q, fz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hx_q <= '0; hy_q <= '0; hz_q <= '0; fr_q <= '0; fz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fbi_pkg::RegHalfX:  hx_q <= cfg_data_i;
        fbi_pkg::RegHalfY:  hy_q <= cfg_data_i;
        fbi_pkg::RegHalfZ:  hz_q <= cfg_data_i;
        fbi_pkg::RegFillet: fr_q <= cfg_data_i;
        fbi_pkg::RegFuzz:   fz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: absolute values
  logic          v1_q;
  logic [AB-1:0] ax_q, ay_q, az_q;

  function automatic logic [AB-1:0] abs_c(input logic signed [COORD_BITS-1:0] v);
    logic [AB-1:0] e;
    e = AB'(unsigned'(v));
    if (v[COORD_BITS-1]) begin
      e = AB'(-$signed({v[COORD_BITS-1], v}));
    end
    return e;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    ax_q <= abs_c(point_x_i);
    ay_q <= abs_c(point_y_i);
    az_q <= abs_c(point_z_i);
  end

  // stage 2: region choice and offsets
  logic [AB-1:0] sx, sy, sz, rx, ry, rz, fz;
  logic          inx, iny, inz, bad, outside;
  assign rx = AB'(hx_q);
  assign ry = AB'(hy_q);
  assign rz = AB'(hz_q);
  assign fz = AB'(fz_q);
  assign sx = rx - AB'(fr_q);
  assign sy = ry - AB'(fr_q);
  assign sz = rz - AB'(fr_q);
  assign bad = (fr_q > hx_q) || (fr_q > hy_q) || (fr_q > hz_q);
  assign outside = (ax_q >= rx + fz) || (ay_q >= ry + fz) || (az_q >= rz + fz);
  assign inx = ax_q <= sx;
  assign iny = ay_q <= sy;
  assign inz = az_q <= sz;

  logic               v2_q;
  fbi_pkg::region_e   reg2_d, reg2_q;
  logic signed [DB-1:0] face2_d, face2_q;
  logic [AB-1:0]      da_d, db_d, dc_d, da_q, db_q, dc_q;

  always_comb begin
    reg2_d  = fbi_pkg::RegionNorm;
    face2_d = '0;
    da_d    = '0;
    db_d    = '0;
    dc_d    = '0;
    if (bad) begin
      reg2_d = fbi_pkg::RegionBad;
    end else if (outside) begin
      reg2_d = fbi_pkg::RegionOut;
    end else if (iny && inz) begin
      reg2_d  = fbi_pkg::RegionFace;
      face2_d = DB'(ax_q) - DB'(rx);
    end else if (inx && inz) begin
      reg2_d  = fbi_pkg::RegionFace;
      face2_d = DB'(ay_q) - DB'(ry);
    end else if (inx && iny) begin
      reg2_d  = fbi_pkg::RegionFace;
      face2_d = DB'(az_q) - DB'(rz);
    end else begin
      if (!inx) da_d = ax_q - sx;
      if (!iny) db_d = ay_q - sy;
      if (!inz) dc_d = az_q - sz;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    reg2_q  <= reg2_d;
    face2_q <= face2_d;
    da_q    <= da_d;
    db_q    <= db_d;
    dc_q    <= dc_d;
  end

  // stage 3: squares
  logic               v3_q;
  fbi_pkg::region_e   reg3_q;
  logic signed [DB-1:0] face3_q;
  logic [2*AB-1:0]    qa_q, qb_q, qc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    reg3_q  <= reg2_q;
    face3_q <= face2_q;
    qa_q    <= da_q * da_q;
    qb_q    <= db_q * db_q;
    qc_q    <= dc_q * dc_q;
  end

  // stage 4: sum
  logic               v4_q;
  fbi_pkg::region_e   reg4_q;
  logic signed [DB-1:0] face4_q;
  logic [SqB-1:0]     sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    reg4_q  <= reg3_q;
    face4_q <= face3_q;
    sum_q   <= SqB'(qa_q) + SqB'(qb_q) + SqB'(qc_q);
  end

  logic               vr;
  logic [RtB-1:0]     root;
  logic [TagB-1:0]    tagr;

  fbi_root #(
    .InBits (SqB),
    .OutBits(RtB),
    .TagBits(TagB)
  ) u_root (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v4_q),
    .rad_i  (sum_q),
    .tag_i  ({reg4_q, face4_q}),
    .valid_o(vr),
    .root_o (root),
    .tag_o  (tagr)
  );

  // stage 5: distance and ramp limits
  fbi_pkg::region_e   regr;
  logic signed [DB-1:0] facer, sdist;
  logic signed [DB-1:0] fzs;
  assign regr  = fbi_pkg::region_e'(tagr[TagB-1 -: 2]);
  assign facer = tagr[DB-1:0];
  assign fzs   = DB'(fz_q);
  assign sdist = (regr == fbi_pkg::RegionNorm) ? (DB'(root) - DB'(fr_q)) : facer;

  logic             v5_q;
  logic             inv5_q, full5_q, zero5_q;
  logic [NB-1:0]    num5_q, den5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= vr;
  end

  always_ff @(posedge clk_i) begin
    inv5_q  <= regr == fbi_pkg::RegionBad;
    full5_q <= (regr != fbi_pkg::RegionBad) && (regr != fbi_pkg::RegionOut)
               && (sdist <= -fzs);
    zero5_q <= (regr == fbi_pkg::RegionBad) || (regr == fbi_pkg::RegionOut)
               || (sdist >= fzs);
    num5_q  <= NB'(fzs - sdist);
    den5_q  <= NB'({fz_q, 1'b0});
  end

  // restoring divider, one quotient bit per stage; num < den so quotient < 2^QB
  logic          dv_q  [QB+1];
  logic          inv_q [QB+1];
  logic          full_q[QB+1];
  logic          zero_q[QB+1];
  logic [NB-1:0] rem_q [QB+1];
  logic [NB-1:0] den_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];

  always_comb begin
    dv_q[0]   = v5_q;
    inv_q[0]  = inv5_q;
    full_q[0] = full5_q;
    zero_q[0] = zero5_q;
    rem_q[0]  = num5_q;
    den_q[0]  = den5_q;
    quo_q[0]  = '0;
  end

  for (genvar s = 0; s < QB; s++) begin : g_div
    logic [NB:0]   tr;
    logic [NB-1:0] rd;
    logic          qb;
    logic          v_r, i_r, f_r, z_r;
    logic [NB-1:0] rm_r, dn_r;
    logic [QB-1:0] q_r;

    always_comb begin
      tr = {rem_q[s], 1'b0};
      qb = tr >= {1'b0, den_q[s]};
      rd = qb ? NB'(tr - {1'b0, den_q[s]}) : NB'(tr);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_r <= 1'b0;
      else         v_r <= dv_q[s];
    end

    always_ff @(posedge clk_i) begin
      i_r  <= inv_q[s];
      f_r  <= full_q[s];
      z_r  <= zero_q[s];
      rm_r <= rd;
      dn_r <= den_q[s];
      q_r  <= {quo_q[s][QB-2:0], qb};
    end

    always_comb begin
      dv_q[s+1]   = v_r;
      inv_q[s+1]  = i_r;
      full_q[s+1] = f_r;
      zero_q[s+1] = z_r;
      rem_q[s+1]  = rm_r;
      den_q[s+1]  = dn_r;
      quo_q[s+1]  = q_r;
    end
  end

  // output register; full wins over zero when the band is empty
  logic                 done_q, inv_o_q;
  logic [OCC_FRAC_BITS:0] occ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= dv_q[QB];
  end

  always_ff @(posedge clk_i) begin
    inv_o_q <= inv_q[QB];
    if (full_q[QB])      occ_q <= {1'b1, {OCC_FRAC_BITS{1'b0}}};
    else if (zero_q[QB]) occ_q <= '0;
    else                 occ_q <= {1'b0, quo_q[QB]};
  end

  assign done_o           = done_q;
  assign occupancy_o      = occ_q;
  assign config_invalid_o = inv_o_q;

endmodule

>>> tb/tb.sv
// Testbench for filleted_box_indicator: scoreboard-checked random and directed points.
`timescale 1ns / 1ps

class occ_board;
  typedef struct {
    logic [16:0] occ;
    logic        inv;
  } occ_res_t;

  occ_res_t    want_q[$];
  longint      hx, hy, hz, fil, fuz;
  int unsigned errors, checked, inv_seen, band_seen;

  function new();
    hx = 0; hy = 0; hz = 0; fil = 0; fuz = 0;
    errors = 0; checked = 0; inv_seen = 0; band_seen = 0;
  endfunction

  function void set_reg(int unsigned idx, logic [22:0] val);
    case (idx)
      fbi_pkg::RegHalfX:  hx  = longint'(val);
      fbi_pkg::RegHalfY:  hy  = longint'(val);
      fbi_pkg::RegHalfZ:  hz  = longint'(val);
      fbi_pkg::RegFillet: fil = longint'(val);
      fbi_pkg::RegFuzz:   fuz = longint'(val);
      default: ;
    endcase
  endfunction

  function longint unsigned floor_root(longint unsigned s);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function longint dist_of(longint x, longint y, longint z);
    longint sx, sy, sz, a, b, c;
    sx = hx - fil; sy = hy - fil; sz = hz - fil;
    if (y <= sy && z <= sz) return x - hx;
    if (x <= sx && z <= sz) return y - hy;
    if (x <= sx && y <= sy) return z - hz;
    a = (x > sx) ? x - sx : 0;
    b = (y > sy) ? y - sy : 0;
    c = (z > sz) ? z - sz : 0;
    if (z <= sz) c = 0;
    else if (y <= sy) b = 0;
    else if (x <= sx) a = 0;
    return longint'(floor_root(a * a + b * b + c * c)) - fil;
  endfunction

  function void note(logic signed [23:0] px, logic signed [23:0] py, logic signed [23:0] pz);
    occ_res_t e;
    longint   x, y, z, d;
    x = (px < 0) ? -longint'(px) : longint'(px);
    y = (py < 0) ? -longint'(py) : longint'(py);
    z = (pz < 0) ? -longint'(pz) : longint'(pz);
    e.inv = 1'b0;
    e.occ = '0;
    if (fil > hx || fil > hy || fil > hz) begin
      e.inv = 1'b1;
    end else if (x < hx + fuz && y < hy + fuz && z < hz + fuz) begin
      d = dist_of(x, y, z);
      if (d <= -fuz) e.occ = 17'h10000;
      else if (d >= fuz) e.occ = '0;
      else e.occ = 17'(((fuz - d) <<< 16) / (2 * fuz));
    end
    want_q.push_back(e);
  endfunction

  function void check(logic [16:0] occ, logic inv);
    occ_res_t e;
    checked++;
    if (want_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result occ=%0d inv=%0b", occ, inv);
      return;
    end
    e = want_q.pop_front();
    if (inv) inv_seen++;
    if (occ != 0 && occ != 17'h10000) band_seen++;
    if (occ !== e.occ || inv !== e.inv) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: occ exp %0d got %0d, invalid exp %0b got %0b",
                 e.occ, occ, e.inv, inv);
    end
  endfunction
endclass

module tb;

  localparam int unsigned WdLimit = 5000;
  localparam logic [2:0]  IdxSpare = 3'd6;
  localparam logic [2:0]  IdxLast  = 3'd7;

  logic                clk_i, rst_ni, start_i, busy_o, cfg_we_i, done_o, config_invalid_o;
  logic signed [23:0]  point_x_i, point_y_i, point_z_i;
  logic [2:0]          cfg_idx_i;
  logic [22:0]         cfg_data_i;
  logic [16:0]         occupancy_o;

  occ_board    board;
  int unsigned sent = 0;
  int unsigned wd = 0;
  bit          idle_on;

  filleted_box_indicator dut (.*);

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        board.note(point_x_i, point_y_i, point_z_i);
        sent++;
      end
      if (done_o) begin
        board.check(occupancy_o, config_invalid_o);
      end
      if ((start_i && !busy_o) || done_o) wd <= 0;
      else                                 wd <= wd + 1;
      if (wd >= WdLimit) begin
        $display("timeout: no request or result for %0d cycles", WdLimit);
        $display("filleted_box_indicator verification failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    board.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic drain();
    while (board.want_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_box(logic [22:0] x, logic [22:0] y, logic [22:0] z,
                         logic [22:0] f, logic [22:0] fz);
    drain();
    write_reg(fbi_pkg::RegHalfX, x);
    write_reg(fbi_pkg::RegHalfY, y);
    write_reg(fbi_pkg::RegHalfZ, z);
    write_reg(fbi_pkg::RegFillet, f);
    write_reg(fbi_pkg::RegFuzz, fz);
  endtask

  task automatic send_point(logic signed [23:0] x, logic signed [23:0] y,
                            logic signed [23:0] z);
    bit b;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    do begin
      @(negedge clk_i);
      b = busy_o;
      @(posedge clk_i);
    end while (b);
  endtask

  task automatic stop_req();
    start_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [22:0] rnd_len();
    int unsigned k;
    k = $urandom_range(3, 23);
    return 23'($urandom() & ((32'd1 << k) - 1));
  endfunction

  function automatic logic signed [23:0] near_coord(longint lim);
    longint v;
    if (lim > 8388607) lim = 8388607;
    v = longint'($urandom_range(0, int'(lim)));
    return 24'($urandom_range(0, 1) ? -v : v);
  endfunction

  task automatic random_phase(int unsigned n);
    logic [22:0] x, y, z, f, fz;
    longint      m, lx, ly, lz;
    x = rnd_len(); y = rnd_len(); z = rnd_len();
    m = x; if (y < m) m = y; if (z < m) m = z;
    f = ($urandom_range(0, 9) == 0) ? rnd_len() : 23'($urandom_range(0, int'(m)));
    fz = ($urandom_range(0, 7) == 0) ? 23'd0 : rnd_len();
    set_box(x, y, z, f, fz);
    lx = longint'(x) + fz + 4; ly = longint'(y) + fz + 4; lz = longint'(z) + fz + 4;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 7)
        send_point(near_coord(lx), near_coord(ly), near_coord(lz));
      else
        send_point(24'($urandom()), 24'($urandom()), 24'($urandom()));
    end
    stop_req();
  endtask

  initial begin
    board      = new();
    idle_on    = 1'b1;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    point_x_i  = '0;
    point_y_i  = '0;
    point_z_i  = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: zero box, zero fuzz
    send_point(24'sd0, 24'sd0, 24'sd0);
    send_point(24'sd1, 24'sd0, 24'sd0);
    stop_req();

    set_box(23'd1000, 23'd1500, 23'd2000, 23'd200, 23'd100);
    send_point(24'sd950, 24'sd10, 24'sd10);      // x face
    send_point(24'sd10, -24'sd1450, 24'sd10);    // y face
    send_point(24'sd10, 24'sd10, -24'sd1990);    // z face
    send_point(24'sd900, 24'sd1400, 24'sd0);     // xy edge
    send_point(-24'sd900, 24'sd0, 24'sd1900);    // xz edge
    send_point(24'sd0, 24'sd1400, 24'sd1900);    // yz edge
    send_point(24'sd930, -24'sd1430, 24'sd1930); // corner
    send_point(24'sd1099, 24'sd0, 24'sd0);
    send_point(24'sd1100, 24'sd0, 24'sd0);
    send_point(-24'sd8388608, -24'sd8388608, -24'sd8388608);
    send_point(24'sd8388607, 24'sd8388607, 24'sd8388607);
    stop_req();

    // spare indices must be ignored
    drain();
    write_reg(IdxSpare, 23'h7fffff);
    write_reg(IdxLast, 23'h7fffff);
    send_point(24'sd950, 24'sd10, 24'sd10);
    stop_req();

    set_box(23'd1000, 23'd1000, 23'd1000, 23'd1001, 23'd50); // fillet too big
    send_point(24'sd0, 24'sd0, 24'sd0);
    send_point(24'sd5000, 24'sd0, 24'sd0);
    stop_req();

    set_box(23'd1000, 23'd1000, 23'd1000, 23'd0, 23'd0);
    send_point(24'sd1000, 24'sd0, 24'sd0);
    send_point(24'sd1001, 24'sd0, 24'sd0);
    stop_req();

    set_box(23'h7fffff, 23'h7fffff, 23'h7fffff, 23'h7fffff, 23'h7fffff);
    send_point(-24'sd8388608, 24'sd8388607, 24'sd0);
    send_point(24'sd12345, -24'sd8388608, 24'sd8388607);
    stop_req();

    for (int p = 0; p < 10; p++) random_phase(100);
    idle_on = 1'b0;
    random_phase(50);

    drain();
    repeat (60) @(posedge clk_i);
    $display("%0d points over 16 box settings; %0d invalid-config and %0d fractional results",
             sent, board.inv_seen, board.band_seen);
    if (board.errors == 0 && board.want_q.size() == 0) begin
      $display("filleted_box_indicator verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors, board.want_q.size());
      $display("filleted_box_indicator verification failed");
    end
    $finish;
  end
endmodule
